>>> rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Types and constants shared by the point region ray locate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

  localparam int unsigned MaxWalls    = 1024;
  localparam int unsigned IdxBits     = 10;
  localparam int unsigned CountBits   = 11;
  localparam int unsigned EpsBits     = 17;
  localparam int unsigned RegionBits  = 8;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned AddrBits    = 3;

  // Register byte addresses
  localparam logic [AddrBits-1:0] RegWallCount   = 3'd0;
  localparam logic [AddrBits-1:0] RegFlatEpsilon = 3'd4;

  // Item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [IdxBits-1:0]    wall_index;
    logic signed [31:0]    end1_x;
    logic signed [31:0]    end1_y;
    logic signed [31:0]    end2_x;
    logic signed [31:0]    end2_y;
    logic [RegionBits-1:0] front_region;
    logic [RegionBits-1:0] back_region;
    logic signed [31:0]    point_x;
    logic signed [31:0]    point_y;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [RegionBits-1:0] region;
    logic signed [31:0]    hit_distance;
  } result_t;

  typedef struct packed {
    logic signed [31:0]    x1;
    logic signed [31:0]    y1;
    logic signed [31:0]    x2;
    logic signed [31:0]    y2;
    logic [RegionBits-1:0] front;
    logic [RegionBits-1:0] back;
  } wall_t;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRead  = 9'b000000010,
    StCheck = 9'b000000100,
    StDiv   = 9'b000001000,
    StSat   = 9'b000010000,
    StMul1  = 9'b000100000,
    StMul2  = 9'b001000000,
    StAcc   = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

>>> rtl/point_region_ray_locate.sv
// ----------------------------------------------------------------------------
// point_region_ray_locate
// Wall table with a horizontal ray search that returns the nearest region.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. A write item
// stores one wall in the table in that cycle and gives no result. A query
// item raises busy and walks walls 0 .. wall_count-1 (at most 1024) from
// the table memory, one wall at a time. Each wall is read (StRead) and
// checked (StCheck); a wall whose span misses the point's y is skipped, a
// near-horizontal wall goes straight to StAcc, and a sloped wall first runs
// the bit-serial 49-step divider that forms the wall's x/y slope, then
// StSat and the multiply states StMul1 and StMul2. StDone ends the query.
// The result shows on result_o with result_valid_o for exactly one cycle;
// the receiver cannot stall it. The user must write registers wall_count
// and flat_epsilon (APB port) only while idle; the block does not enforce it.
// Reset clears the registers (wall_count 0, flat_epsilon 1) and the control;
// the table content is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_region_ray_locate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire prl_pkg::item_t                item_i,
  output prl_pkg::result_t                   result_o,
  output logic                               result_valid_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prl_pkg::AddrBits-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  prl_pkg::state_e state_q, state_d;

  logic [prl_pkg::CountBits-1:0] count_q;
  logic [prl_pkg::EpsBits-1:0]   eps_q;

  prl_pkg::wall_t mem [prl_pkg::MaxWalls];
  prl_pkg::wall_t rd_q;

  logic [prl_pkg::CountBits-1:0] n_q, idx_q;
  logic signed [31:0]            px_q, py_q;
  logic [48:0]                   num_q;
  logic [33:0]                   rem_q;
  logic [32:0]                   den_q;
  logic                          neg_q;
  logic [5:0]                    cnt_q;
  logic signed [31:0]            quo_q;
  logic signed [32:0]            dyp_q;
  logic signed [64:0]            prod_q;
  logic signed [50:0]            dist_q;
  logic [31:0]                   best_q;
  logic                          hit_q;
  logic [prl_pkg::RegionBits-1:0] reg_q;
  logic                          out_vld_q;
  logic                          from_mul_q;
  logic signed [50:0]            dist_sel;

  logic accept, wr_item, cfg_wr;
  assign accept  = start && !busy;
  assign wr_item = accept && (item_i.kind == prl_pkg::KindWrite);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign busy    = (state_q != prl_pkg::StIdle);
  assign pready  = 1'b1;

  // Clamp the programmed wall count to the table depth
  function automatic logic [prl_pkg::CountBits-1:0] n_next();
    n_next = (count_q > prl_pkg::CountBits'(prl_pkg::MaxWalls)) ?
             prl_pkg::CountBits'(prl_pkg::MaxWalls) : count_q;
  endfunction

  // Register read
  always_comb begin
    prdata = 32'd0;
    unique case (paddr)
      prl_pkg::RegWallCount:   prdata = {{(32-prl_pkg::CountBits){1'b0}}, count_q};
      prl_pkg::RegFlatEpsilon: prdata = {{(32-prl_pkg::EpsBits){1'b0}}, eps_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      eps_q   <= prl_pkg::EpsBits'(1);
    end else if (cfg_wr) begin
      if (paddr == prl_pkg::RegWallCount) begin
        count_q <= pwdata[prl_pkg::CountBits-1:0];
      end
      if (paddr == prl_pkg::RegFlatEpsilon) begin
        eps_q <= pwdata[prl_pkg::EpsBits-1:0];
      end
    end
  end

  // Wall table: write on a write item, read the current index every cycle
  always_ff @(posedge clk_i) begin
    if (wr_item) begin
      mem[item_i.wall_index] <= '{x1: item_i.end1_x, y1: item_i.end1_y,
                                  x2: item_i.end2_x, y2: item_i.end2_y,
                                  front: item_i.front_region,
                                  back: item_i.back_region};
    end
    rd_q <= mem[idx_q[prl_pkg::IdxBits-1:0]];
  end

  // Per-wall combinational terms
  logic        in_span, flat, last;
  logic signed [32:0] dy, dx, d1, d2;
  logic [32:0] ady, adx;
  logic [33:0] rem_sh;
  logic        ge;
  logic signed [48:0] p1, p2;
  logic signed [50:0] dist_mul;
  logic signed [31:0] q_sat;

  always_comb begin
    in_span = ((py_q >= rd_q.y1) && (py_q < rd_q.y2)) ||
              ((py_q >= rd_q.y2) && (py_q < rd_q.y1));
    dy   = 33'(rd_q.y1) - 33'(rd_q.y2);
    dx   = 33'(rd_q.x1) - 33'(rd_q.x2);
    ady  = dy[32] ? 33'(-dy) : 33'(dy);
    adx  = dx[32] ? 33'(-dx) : 33'(dx);
    flat = ady < {16'd0, eps_q};
    d1   = 33'(rd_q.x1) - 33'(px_q);
    d2   = 33'(rd_q.x2) - 33'(px_q);
    last = (idx_q + prl_pkg::CountBits'(1)) == n_q;
    // One restoring division step
    rem_sh = {rem_q[32:0], num_q[48]};
    ge     = rem_sh >= {1'b0, den_q};
    // Saturate the quotient magnitude to signed 32 bits
    if (neg_q) begin
      q_sat = (num_q > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-num_q[31:0]);
    end else begin
      q_sat = (num_q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(num_q[31:0]);
    end
    p1 = quo_q * $signed({1'b0, dyp_q[15:0]});
    p2 = quo_q * $signed(dyp_q[32:16]);
    // Floor the product by an arithmetic shift, then offset to the point
    dist_mul = 51'($signed(prod_q[64:16])) + 51'(rd_q.x1) - 51'(px_q);
  end

  // Flat walls arrive with the distance already held; sloped ones add up here
  assign dist_sel = from_mul_q ? dist_mul : dist_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prl_pkg::StIdle: begin
        if (accept && item_i.kind == prl_pkg::KindQuery) begin
          state_d = (n_next() == '0) ? prl_pkg::StDone : prl_pkg::StRead;
        end
      end
      prl_pkg::StRead:  state_d = prl_pkg::StCheck;
      prl_pkg::StCheck: begin
        if (!in_span) begin
          state_d = last ? prl_pkg::StDone : prl_pkg::StRead;
        end else if (flat) begin
          state_d = prl_pkg::StAcc;
        end else begin
          state_d = prl_pkg::StDiv;
        end
      end
      prl_pkg::StDiv:  state_d = (cnt_q == '0) ? prl_pkg::StSat : prl_pkg::StDiv;
      prl_pkg::StSat:  state_d = prl_pkg::StMul1;
      prl_pkg::StMul1: state_d = prl_pkg::StMul2;
      prl_pkg::StMul2: state_d = prl_pkg::StAcc;
      prl_pkg::StAcc:  state_d = last ? prl_pkg::StDone : prl_pkg::StRead;
      prl_pkg::StDone: state_d = prl_pkg::StIdle;
      default:         state_d = prl_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= prl_pkg::StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= (state_q == prl_pkg::StDone);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      prl_pkg::StIdle: begin
        // Start a query
        idx_q  <= '0;
        n_q    <= n_next();
        px_q   <= item_i.point_x;
        py_q   <= item_i.point_y;
        best_q <= 32'h7FFF_FFFF;
        hit_q  <= 1'b0;
        reg_q  <= '0;
      end
      prl_pkg::StCheck: begin
        dyp_q <= 33'(py_q) - 33'(rd_q.y1);
        if (!in_span) begin
          idx_q <= idx_q + prl_pkg::CountBits'(1);
        end else if (flat) begin
          dist_q <= (d1 < d2) ? 51'(d1) : 51'(d2);
        end else begin
          // Set up |dx| * 2^16 / |dy|
          num_q <= {adx, {prl_pkg::FracBits{1'b0}}};
          den_q <= ady;
          rem_q <= '0;
          neg_q <= dx[32] ^ dy[32];
          cnt_q <= 6'd48;
        end
      end
      prl_pkg::StDiv: begin
        rem_q <= ge ? 34'(rem_sh - {1'b0, den_q}) : rem_sh;
        num_q <= {num_q[47:0], ge};
        cnt_q <= cnt_q - 6'd1;
      end
      prl_pkg::StSat: begin
        quo_q <= (den_q == '0) ? 32'sd0 : q_sat;
      end
      prl_pkg::StMul1: begin
        prod_q <= 65'(p1);
      end
      prl_pkg::StMul2: begin
        prod_q <= prod_q + $signed({p2, {prl_pkg::FracBits{1'b0}}});
      end
      prl_pkg::StAcc: begin
        // Keep the nearest positive hit
        if ((dist_sel > 51'sd0) && (dist_sel < $signed({19'd0, best_q}))) begin
          best_q <= dist_sel[31:0];
          hit_q  <= 1'b1;
          reg_q  <= (rd_q.y1 < rd_q.y2) ? rd_q.front : rd_q.back;
        end
        idx_q <= idx_q + prl_pkg::CountBits'(1);
      end
      default: begin
      end
    endcase
  end

  // Mark whether the held distance comes from the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_mul_q <= 1'b0;
    end else if (state_q == prl_pkg::StMul2) begin
      from_mul_q <= 1'b1;
    end else if (state_q == prl_pkg::StCheck) begin
      from_mul_q <= 1'b0;
    end
  end

  // Result
  assign result_valid_o        = out_vld_q;
  assign result_o.found        = hit_q;
  assign result_o.region       = reg_q;
  assign result_o.hit_distance = $signed(best_q);

endmodule

`default_nettype wire
